FILE: hdl/ljpf_pkg.sv
package ljpf_pkg;

	localparam int POSITION_FRACTION_BITS = 16;
	localparam int MAX_PARTICLES = 65536;

	localparam int IN_W = 240;
	localparam int OUT_W = 248;
	localparam int N_SLOTS = 10;
	localparam int SLOT_W = 4;

	localparam logic [1:0] KIND_PAIR = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_CLR = 2'd2;

	localparam logic [2:0] CFG_CUTOFF_SQ = 3'd0;
	localparam logic [2:0] CFG_SIGMA_SQ = 3'd1;
	localparam logic [2:0] CFG_EPSILON = 3'd2;
	localparam logic [2:0] CFG_ATTRACT = 3'd3;
	localparam logic [2:0] CFG_BOX_X = 3'd4;
	localparam logic [2:0] CFG_BOX_Y = 3'd5;
	localparam logic [2:0] CFG_BOX_Z = 3'd6;
	localparam logic [2:0] CFG_TYPES = 3'd7;

	localparam logic [SLOT_W-1:0] SLOT_ENERGY = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_LAST = 4'd9;

	// bit positions inside m_tdata
	localparam int OB_HIT = 176;
	localparam int OB_SLOT = 177;

	typedef struct packed {
		logic start;
		logic [63:0] a;
		logic [63:0] b;
		logic [5:0] sh;
	} mul_req_t;

	typedef struct packed {
		logic start;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic clear;
		logic rd_en;
		logic wr_en;
		logic [SLOT_W-1:0] addr;
	} acc_req_t;

endpackage

FILE: hdl/ljpf_mul.sv
module ljpf_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  ljpf_pkg::mul_req_t req,
	output logic              done,
	output logic [63:0]       res
);
	import ljpf_pkg::*;

	logic         busy_q;
	logic [2:0]   cnt_q;
	logic [63:0]  a_q, b_q;
	logic [5:0]   sh_q;
	logic [63:0]  p_q;
	logic [1:0]   pw_q;
	logic [127:0] acc_q;
	logic [31:0]  a_sel, b_sel;
	logic [127:0] shifted;
	logic [63:0]  hi_sh;

	assign a_sel = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_sel = cnt_q[0] ? b_q[63:32] : b_q[31:0];
	assign shifted = acc_q >> sh_q;
	assign hi_sh = acc_q[127:64] >> sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 3'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			sh_q <= req.sh;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				p_q <= a_sel * b_sel;
				pw_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4)
				acc_q <= acc_q + (128'(p_q) << {pw_q, 5'b0});
			if (cnt_q == 3'd5)
				res <= (hi_sh != 64'd0) ? '1 : shifted[63:0];
		end
	end

endmodule

FILE: hdl/ljpf_div.sv
module ljpf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ljpf_pkg::div_req_t req,
	output logic              done,
	output logic [63:0]       quo
);
	import ljpf_pkg::*;

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q, lo_q, den_q;
	logic [64:0] rem_w, diff;
	logic        ge;

	assign rem_w = {rem_q, lo_q[63]};
	assign ge = rem_w >= {1'b0, den_q};
	assign diff = rem_w - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 6'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				cnt_q <= 6'd0;
				if (req.den == 64'd0 || req.hi >= req.den)
					done <= 1'b1;
				else
					busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.hi;
			lo_q <= req.lo;
			den_q <= req.den;
			quo <= (req.den == 64'd0 || req.hi >= req.den) ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : rem_w[63:0];
			lo_q <= {lo_q[62:0], 1'b0};
			quo <= {quo[62:0], ge};
		end
	end

endmodule

FILE: hdl/ljpf_acc.sv
module ljpf_acc (
	input  logic              clk,
	input  logic              arst_n,
	input  ljpf_pkg::acc_req_t req,
	input  logic [63:0]       wr_data,
	output logic [63:0]       rd_data
);
	import ljpf_pkg::*;

	logic [63:0]        mem [N_SLOTS];
	logic [N_SLOTS-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (req.clear)
			valid_q <= '0;
		else if (req.wr_en)
			valid_q[req.addr] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.addr] <= wr_data;
		if (req.rd_en)
			rd_data <= valid_q[req.addr] ? mem[req.addr] : 64'd0;
	end

endmodule

FILE: hdl/lj_pair_force_core.sv
// Lennard-Jones pair force core. One beat in at a time: s_tready is high only while idle.
// A pair beat that interacts runs 29 64-bit products through one shared 32x32 multiplier
// (four partial products plus shift and saturate each; three products for a pair that does
// not interact) and two quotients through a one-bit-per-cycle divider. A read beat gives
// ten result beats; a clear beat gives none and only clears the totals. The result
// register lets the next input beat in while a result waits.
module lj_pair_force_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// first_index, second_index, first_type, second_type, first_x/y/z, second_x/y/z
	input  logic [ljpf_pkg::IN_W-1:0]    s_tdata,
	// kind
	input  logic [1:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// pair_first, pair_second, force_x/y/z, interacted, total_slot, total_value, pad
	output logic [ljpf_pkg::OUT_W-1:0]   m_tdata,
	output logic                         m_tlast
);
	import ljpf_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_WRAP = 5'd1;
	localparam logic [4:0] S_SQ   = 5'd2;
	localparam logic [4:0] S_CHK  = 5'd3;
	localparam logic [4:0] S_DIVX = 5'd4;
	localparam logic [4:0] S_XX   = 5'd5;
	localparam logic [4:0] S_X3   = 5'd6;
	localparam logic [4:0] S_FA   = 5'd7;
	localparam logic [4:0] S_FB   = 5'd8;
	localparam logic [4:0] S_FC   = 5'd9;
	localparam logic [4:0] S_FT   = 5'd10;
	localparam logic [4:0] S_FRC  = 5'd11;
	localparam logic [4:0] S_DIVQ = 5'd12;
	localparam logic [4:0] S_QQ   = 5'd13;
	localparam logic [4:0] S_Q3   = 5'd14;
	localparam logic [4:0] S_EA1  = 5'd15;
	localparam logic [4:0] S_EA2  = 5'd16;
	localparam logic [4:0] S_EA4  = 5'd17;
	localparam logic [4:0] S_EB1  = 5'd18;
	localparam logic [4:0] S_EB2  = 5'd19;
	localparam logic [4:0] S_EB4  = 5'd20;
	localparam logic [4:0] S_ERD  = 5'd21;
	localparam logic [4:0] S_EWR  = 5'd22;
	localparam logic [4:0] S_VM   = 5'd23;
	localparam logic [4:0] S_VRD  = 5'd24;
	localparam logic [4:0] S_VWR  = 5'd25;
	localparam logic [4:0] S_OUT  = 5'd26;
	localparam logic [4:0] S_RRD  = 5'd27;
	localparam logic [4:0] S_ROUT = 5'd28;

	localparam int DIV_SH = 16 + 2 * POSITION_FRACTION_BITS;
	localparam int CUT_SH = 2 * POSITION_FRACTION_BITS - 16;
	localparam logic [5:0] SH_MUL = 6'd32;
	localparam logic [5:0] SH_FORCE = 6'(8 + POSITION_FRACTION_BITS);
	localparam logic [5:0] SH_VIR = 6'(POSITION_FRACTION_BITS);
	localparam logic [63:0] F48_MAX = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

	logic [4:0] state_q;
	logic       issued_q;
	logic [1:0] ax_q, vk_q;
	logic [SLOT_W-1:0] slot_q;

	logic [31:0] cut_q, sig_q, eps_q, aw_q;
	logic [30:0] box_q [3];
	logic [15:0] codes_q;

	logic [15:0] i1_q, i2_q;
	logic [7:0]  t1_q, t2_q;
	logic [31:0] pa_q [3];
	logic [31:0] pb_q [3];

	logic [33:0] rmag_q [3];
	logic [2:0]  rneg_q;
	logic        far_q, hit_q;
	logic [63:0] r2_q, x_q, x3_q, t_q, ft_q;
	logic        fneg_q, eneg_q, vneg_q;
	logic signed [47:0] f_q [3];
	logic signed [63:0] e_q;

	logic        o_valid_q, o_hit_q, o_last_q;
	logic [15:0] o_first_q, o_second_q;
	logic [47:0] o_f_q [3];
	logic [SLOT_W-1:0] o_slot_q;
	logic [63:0] o_val_q;

	mul_req_t mreq;
	div_req_t dreq;
	acc_req_t areq;
	logic        mul_done, div_done;
	logic [63:0] mul_res, div_quo, acc_rd, acc_wd;

	logic        is_mul, is_div, unit_done, out_free, hit, o_load;
	logic [33:0] rmag_w [3];
	logic [2:0]  rneg_w;
	logic        far_w;
	logic [63:0] w_ft, w_en, eps16, d_x3f, d_x3e, d_qe, cut_ext;
	logic [127:0] sig_sh;
	logic [64:0] r2_sum;
	logic [47:0] fabs;

	function automatic logic type_ok(input logic [7:0] t, input logic [15:0] c);
		return t == c[7:0] || t == c[15:8];
	endfunction

	function automatic logic [63:0] absdiff(input logic [63:0] a, input logic [63:0] b);
		return (a < b) ? b - a : a - b;
	endfunction

	function automatic logic signed [47:0] sat48(input logic neg, input logic [63:0] m);
		if (m > F48_MAX)
			return neg ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		return neg ? -$signed(m[47:0]) : $signed(m[47:0]);
	endfunction

	function automatic logic signed [63:0] sat64(input logic neg, input logic [63:0] m);
		if (m[63])
			return neg ? I64_MIN : I64_MAX;
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? I64_MIN : I64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] energy(input logic neg, input logic [63:0] m);
		logic signed [63:0] v;
		v = $signed({8'd0, m[63:8]});
		return neg ? -v : v;
	endfunction

	ljpf_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .done(mul_done), .res(mul_res));
	ljpf_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(div_done), .quo(div_quo));
	ljpf_acc u_acc (.clk(clk), .arst_n(arst_n), .req(areq), .wr_data(acc_wd),
		.rd_data(acc_rd));

	// minimum image per axis
	always_comb begin
		logic signed [32:0] dd;
		logic signed [34:0] twice, bb;
		logic signed [33:0] dw;
		far_w = 1'b0;
		for (int k = 0; k < 3; k++) begin
			dd = $signed({pa_q[k][31], pa_q[k]}) - $signed({pb_q[k][31], pb_q[k]});
			twice = {dd[32], dd, 1'b0};
			bb = $signed({4'd0, box_q[k]});
			dw = {dd[32], dd};
			if (twice > bb)
				dw = dw - $signed({3'd0, box_q[k]});
			else if (twice < -bb)
				dw = dw + $signed({3'd0, box_q[k]});
			rneg_w[k] = dw[33];
			rmag_w[k] = dw[33] ? 34'(-dw) : 34'(dw);
			if (rmag_w[k] > 34'h0_FFFF_FFFF)
				far_w = 1'b1;
		end
	end

	assign w_ft = {17'd0, aw_q, 15'd0};
	assign w_en = {16'd0, aw_q, 16'd0};
	assign eps16 = {16'd0, eps_q, 16'd0};
	assign d_x3f = absdiff(x3_q, w_ft);
	assign d_x3e = absdiff(x3_q, w_en);
	assign d_qe = absdiff(x_q, w_en);
	assign cut_ext = 64'(cut_q) << CUT_SH;
	assign sig_sh = 128'(sig_q) << DIV_SH;
	assign r2_sum = {1'b0, r2_q} + {1'b0, mul_res};
	assign fabs = f_q[vk_q][47] ? 48'(-f_q[vk_q]) : 48'(f_q[vk_q]);

	assign hit = type_ok(t1_q, codes_q) && type_ok(t2_q, codes_q)
		&& 32'(i1_q) < 32'(MAX_PARTICLES) && 32'(i2_q) < 32'(MAX_PARTICLES)
		&& !far_q && r2_q != 64'd0 && r2_q < cut_ext;

	always_comb begin
		is_mul = 1'b0;
		is_div = 1'b0;
		unique case (state_q) inside
			S_SQ, S_XX, S_X3, S_FA, S_FB, S_FC, S_FT, S_FRC, S_QQ, S_Q3,
			S_EA1, S_EA2, S_EA4, S_EB1, S_EB2, S_EB4, S_VM: is_mul = 1'b1;
			S_DIVX, S_DIVQ: is_div = 1'b1;
			default: ;
		endcase
	end

	assign unit_done = is_mul ? mul_done : div_done;

	always_comb begin
		mreq = '0;
		mreq.start = is_mul && !issued_q;
		mreq.sh = SH_MUL;
		unique case (state_q)
			S_SQ: begin
				mreq.a = {32'd0, rmag_q[ax_q][31:0]};
				mreq.b = {32'd0, rmag_q[ax_q][31:0]};
				mreq.sh = 6'd0;
			end
			S_XX: begin mreq.a = x_q; mreq.b = x_q; end
			S_X3: begin mreq.a = t_q; mreq.b = x_q; end
			S_FA: begin mreq.a = x3_q; mreq.b = d_x3f; end
			S_FB: begin mreq.a = t_q; mreq.b = eps16; end
			S_FC: begin mreq.a = t_q; mreq.b = x_q; end
			S_FT: begin mreq.a = t_q; mreq.b = 64'd48; mreq.sh = 6'd0; end
			S_FRC: begin
				mreq.a = ft_q;
				mreq.b = 64'(rmag_q[ax_q]);
				mreq.sh = SH_FORCE;
			end
			S_QQ: begin mreq.a = x_q; mreq.b = x_q; end
			S_Q3: begin mreq.a = t_q; mreq.b = x_q; end
			S_EA1: begin mreq.a = x3_q; mreq.b = d_x3e; end
			S_EB1: begin mreq.a = x_q; mreq.b = d_qe; end
			S_EA2, S_EB2: begin mreq.a = t_q; mreq.b = eps16; end
			S_EA4, S_EB4: begin mreq.a = t_q; mreq.b = 64'd4; mreq.sh = 6'd0; end
			S_VM: begin
				mreq.a = 64'(fabs);
				mreq.b = 64'(rmag_q[ax_q]);
				mreq.sh = SH_VIR;
			end
			default: ;
		endcase
	end

	always_comb begin
		dreq = '0;
		dreq.start = is_div && !issued_q;
		if (state_q == S_DIVX) begin
			dreq.hi = sig_sh[127:64];
			dreq.lo = sig_sh[63:0];
			dreq.den = r2_q;
		end else begin
			dreq.lo = {sig_q, 32'd0};
			dreq.den = {32'd0, cut_q};
		end
	end

	always_comb begin
		areq.clear = (state_q == S_IDLE) && s_tvalid && s_tuser == KIND_CLR;
		areq.rd_en = state_q == S_ERD || state_q == S_VRD || state_q == S_RRD;
		areq.wr_en = state_q == S_EWR || state_q == S_VWR;
		areq.addr = (state_q == S_ERD || state_q == S_EWR) ? SLOT_ENERGY : slot_q;
		acc_wd = (state_q == S_EWR) ? sadd(acc_rd, e_q) : sadd(acc_rd, sat64(vneg_q, t_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q <= 32'd409600;
			sig_q <= 32'd65536;
			eps_q <= 32'd65536;
			aw_q <= 32'd65536;
			box_q[0] <= 31'd655360;
			box_q[1] <= 31'd655360;
			box_q[2] <= 31'd655360;
			codes_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CUTOFF_SQ: cut_q <= cfg_data;
				CFG_SIGMA_SQ: sig_q <= cfg_data;
				CFG_EPSILON: eps_q <= cfg_data;
				CFG_ATTRACT: aw_q <= cfg_data;
				CFG_BOX_X: box_q[0] <= cfg_data[30:0];
				CFG_BOX_Y: box_q[1] <= cfg_data[30:0];
				CFG_BOX_Z: box_q[2] <= cfg_data[30:0];
				CFG_TYPES: codes_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign out_free = !o_valid_q || m_tready;
	assign o_load = out_free && (state_q == S_OUT || state_q == S_ROUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issued_q <= 1'b0;
			ax_q <= 2'd0;
			vk_q <= 2'd0;
			slot_q <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (o_load)
				o_valid_q <= 1'b1;
			else if (m_tready)
				o_valid_q <= 1'b0;
			if (is_mul || is_div)
				issued_q <= issued_q ? !unit_done : 1'b1;
			unique case (state_q)
				S_IDLE: if (s_tvalid) begin
					i1_q <= s_tdata[15:0];
					i2_q <= s_tdata[31:16];
					t1_q <= s_tdata[39:32];
					t2_q <= s_tdata[47:40];
					pa_q[0] <= s_tdata[79:48];
					pa_q[1] <= s_tdata[111:80];
					pa_q[2] <= s_tdata[143:112];
					pb_q[0] <= s_tdata[175:144];
					pb_q[1] <= s_tdata[207:176];
					pb_q[2] <= s_tdata[239:208];
					case (s_tuser)
						KIND_PAIR: state_q <= S_WRAP;
						KIND_READ: begin
							slot_q <= SLOT_ENERGY;
							state_q <= S_RRD;
						end
						default: ;
					endcase
				end
				S_WRAP: begin
					for (int k = 0; k < 3; k++)
						rmag_q[k] <= rmag_w[k];
					rneg_q <= rneg_w;
					far_q <= far_w;
					r2_q <= 64'd0;
					ax_q <= 2'd0;
					state_q <= S_SQ;
				end
				S_SQ: if (issued_q && mul_done) begin
					r2_q <= r2_sum[64] ? '1 : r2_sum[63:0];
					if (ax_q == 2'd2) begin
						ax_q <= 2'd0;
						state_q <= S_CHK;
					end else
						ax_q <= ax_q + 2'd1;
				end
				S_CHK: begin
					hit_q <= hit;
					if (hit)
						state_q <= S_DIVX;
					else begin
						for (int k = 0; k < 3; k++)
							f_q[k] <= '0;
						state_q <= S_OUT;
					end
				end
				S_DIVX: if (issued_q && div_done) begin
					x_q <= div_quo;
					state_q <= S_XX;
				end
				S_XX: if (issued_q && mul_done) begin t_q <= mul_res; state_q <= S_X3; end
				S_X3: if (issued_q && mul_done) begin x3_q <= mul_res; state_q <= S_FA; end
				S_FA: if (issued_q && mul_done) begin
					t_q <= mul_res;
					fneg_q <= x3_q < w_ft;
					state_q <= S_FB;
				end
				S_FB: if (issued_q && mul_done) begin t_q <= mul_res; state_q <= S_FC; end
				S_FC: if (issued_q && mul_done) begin t_q <= mul_res; state_q <= S_FT; end
				S_FT: if (issued_q && mul_done) begin
					ft_q <= mul_res;
					ax_q <= 2'd0;
					state_q <= S_FRC;
				end
				S_FRC: if (issued_q && mul_done) begin
					f_q[ax_q] <= sat48(fneg_q ^ rneg_q[ax_q], mul_res);
					if (ax_q == 2'd2) begin
						ax_q <= 2'd0;
						state_q <= S_DIVQ;
					end else
						ax_q <= ax_q + 2'd1;
				end
				S_DIVQ: if (issued_q && div_done) begin
					x_q <= div_quo;
					state_q <= S_QQ;
				end
				S_QQ: if (issued_q && mul_done) begin t_q <= mul_res; state_q <= S_Q3; end
				S_Q3: if (issued_q && mul_done) begin x_q <= mul_res; state_q <= S_EA1; end
				S_EA1: if (issued_q && mul_done) begin
					t_q <= mul_res;
					eneg_q <= x3_q < w_en;
					state_q <= S_EA2;
				end
				S_EA2: if (issued_q && mul_done) begin t_q <= mul_res; state_q <= S_EA4; end
				S_EA4: if (issued_q && mul_done) begin
					e_q <= energy(eneg_q, mul_res);
					state_q <= S_EB1;
				end
				S_EB1: if (issued_q && mul_done) begin
					t_q <= mul_res;
					eneg_q <= x_q < w_en;
					state_q <= S_EB2;
				end
				S_EB2: if (issued_q && mul_done) begin t_q <= mul_res; state_q <= S_EB4; end
				S_EB4: if (issued_q && mul_done) begin
					e_q <= e_q - energy(eneg_q, mul_res);
					state_q <= S_ERD;
				end
				S_ERD: state_q <= S_EWR;
				S_EWR: begin
					ax_q <= 2'd0;
					vk_q <= 2'd0;
					slot_q <= SLOT_ENERGY + 4'd1;
					state_q <= S_VM;
				end
				S_VM: if (issued_q && mul_done) begin
					t_q <= mul_res;
					vneg_q <= f_q[vk_q][47] ^ rneg_q[ax_q];
					state_q <= S_VRD;
				end
				S_VRD: state_q <= S_VWR;
				S_VWR: begin
					if (slot_q == SLOT_LAST)
						state_q <= S_OUT;
					else begin
						slot_q <= slot_q + 4'd1;
						if (ax_q == 2'd2) begin
							ax_q <= 2'd0;
							vk_q <= vk_q + 2'd1;
						end else
							ax_q <= ax_q + 2'd1;
						state_q <= S_VM;
					end
				end
				S_OUT: if (out_free) begin
					o_first_q <= i1_q;
					o_second_q <= i2_q;
					for (int k = 0; k < 3; k++)
						o_f_q[k] <= f_q[k];
					o_hit_q <= hit_q;
					o_slot_q <= SLOT_ENERGY;
					o_val_q <= 64'd0;
					o_last_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RRD: state_q <= S_ROUT;
				S_ROUT: if (out_free) begin
					o_first_q <= 16'd0;
					o_second_q <= 16'd0;
					for (int k = 0; k < 3; k++)
						o_f_q[k] <= 48'd0;
					o_hit_q <= 1'b0;
					o_slot_q <= slot_q;
					o_val_q <= acc_rd;
					o_last_q <= slot_q == SLOT_LAST;
					if (slot_q == SLOT_LAST)
						state_q <= S_IDLE;
					else begin
						slot_q <= slot_q + 4'd1;
						state_q <= S_RRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = o_valid_q;
	assign m_tlast = o_last_q;
	assign m_tdata = {3'd0, o_val_q, o_slot_q, o_hit_q, o_f_q[2], o_f_q[1], o_f_q[0],
		o_second_q, o_first_q};

endmodule

FILE: hdl/ljpf_chk.sv
module ljpf_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [1:0]                 s_tuser,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [ljpf_pkg::OUT_W-1:0] m_tdata,
	input logic                       m_tlast
);
	import ljpf_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	a_pair_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == KIND_PAIR |=> !s_tready)
		else $error("pair beat did not make the core busy");

	a_hit_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OB_HIT] |-> m_tlast && m_tdata[OB_SLOT+SLOT_W-1:OB_SLOT] == '0)
		else $error("interacted set on a totals beat");

	a_total_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !m_tdata[OB_HIT]
			&& m_tdata[OB_SLOT+SLOT_W-1:OB_SLOT] != SLOT_LAST)
		else $error("bad non-final totals beat");

endmodule

bind lj_pair_force_core ljpf_chk u_ljpf_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser(s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);
